FILE: rtl/rvaj_pkg.sv
// Shared opcodes, function codes and the execute result type for the RV32I execute block.
package rvaj_pkg;

    // Major opcodes that the block executes.
    localparam logic [6:0] OPC_OP_IMM = 7'b0010011;
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC  = 7'b0010111;
    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;
    localparam logic [6:0] OPC_JALR   = 7'b1100111;

    // Register file geometry.
    localparam int unsigned XLEN       = 32;
    localparam int unsigned REG_COUNT  = 32;
    localparam int unsigned REG_AW     = 5;
    localparam logic [REG_AW-1:0] REG_ZERO = '0;

    // ALU function selected by funct3.
    typedef enum logic [2:0] {
        F3_ADD  = 3'd0,
        F3_SLL  = 3'd1,
        F3_SLT  = 3'd2,
        F3_SLTU = 3'd3,
        F3_XOR  = 3'd4,
        F3_SR   = 3'd5,
        F3_OR   = 3'd6,
        F3_AND  = 3'd7
    } alu_func_t;

    // Everything one instruction produces, committed as one beat.
    typedef struct packed {
        logic              we;
        logic [REG_AW-1:0] rd;
        logic [XLEN-1:0]   val;
        logic [XLEN-1:0]   npc;
        logic              rec;
        logic              halted;
    } exec_result_t;

endpackage

FILE: rtl/rvaj_regfile.sv
// Register file: 32x32 memory with two registered read ports, reset valid bits and write bypass.
module rvaj_regfile
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rd_en,
    input  logic [rvaj_pkg::REG_AW-1:0] rs1_addr,
    input  logic [rvaj_pkg::REG_AW-1:0] rs2_addr,
    input  logic                       wr_en,
    input  logic [rvaj_pkg::REG_AW-1:0] wr_addr,
    input  logic [rvaj_pkg::XLEN-1:0]   wr_data,
    output logic [rvaj_pkg::XLEN-1:0]   rs1_data,
    output logic [rvaj_pkg::XLEN-1:0]   rs2_data
);
    import rvaj_pkg::*;

    logic [XLEN-1:0]      mem [REG_COUNT];
    logic [REG_COUNT-1:0] vld_reg;
    logic [XLEN-1:0]      q1_reg;
    logic [XLEN-1:0]      q2_reg;
    logic                 q1_vld_reg;
    logic                 q2_vld_reg;
    logic                 byp1_reg;
    logic                 byp2_reg;
    logic [XLEN-1:0]      byp_data_reg;

    // Memory write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Memory read ports, held while the reading stage is stalled.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            q1_reg <= mem[rs1_addr];
            q2_reg <= mem[rs2_addr];
        end
    end

    // Per-entry valid bits; an entry never written reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    // A write at the same edge as the read is not yet in the read data, so capture it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q1_vld_reg <= 1'b0;
            q2_vld_reg <= 1'b0;
            byp1_reg   <= 1'b0;
            byp2_reg   <= 1'b0;
        end
        else if (rd_en)
        begin
            q1_vld_reg <= vld_reg[rs1_addr];
            q2_vld_reg <= vld_reg[rs2_addr];
            byp1_reg   <= wr_en && (wr_addr == rs1_addr);
            byp2_reg   <= wr_en && (wr_addr == rs2_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            byp_data_reg <= wr_data;
        end
    end

    // Read data select: bypass first, then stored value if the entry is valid.
    assign rs1_data = byp1_reg ? byp_data_reg : (q1_vld_reg ? q1_reg : '0);
    assign rs2_data = byp2_reg ? byp_data_reg : (q2_vld_reg ? q2_reg : '0);

    // x0 is never written.
    assert property (@(posedge clk) disable iff (!rst_n) wr_en |-> wr_addr != REG_ZERO)
        else $error("write to x0");

    // x0 always reads zero.
    assert property (@(posedge clk) disable iff (!rst_n) !vld_reg[0])
        else $error("x0 marked valid");

    // A write at the read edge is seen on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_en && wr_en && (wr_addr == rs1_addr) |=> rs1_data == $past(wr_data))
        else $error("rs1 bypass lost");

endmodule

FILE: rtl/rvaj_exec.sv
// Execute logic: decode, ALU, link value and next program counter for one instruction.
module rvaj_exec
(
    input  logic [31:0]                 instr,
    input  logic [rvaj_pkg::XLEN-1:0]   pc,
    input  logic [rvaj_pkg::XLEN-1:0]   rs1_val,
    input  logic [rvaj_pkg::XLEN-1:0]   rs2_val,
    output rvaj_pkg::exec_result_t      res
);
    import rvaj_pkg::*;

    logic [6:0]        opc;
    logic [REG_AW-1:0] rd;
    alu_func_t         f3;
    logic              alt;
    logic [XLEN-1:0]   imm_i;
    logic [XLEN-1:0]   imm_j;
    logic [XLEN-1:0]   imm_u;
    logic [XLEN-1:0]   opb;
    logic [4:0]        sh;
    logic [XLEN-1:0]   alu_out;
    logic [XLEN-1:0]   pc4;
    logic [XLEN-1:0]   val;
    logic [XLEN-1:0]   npc;
    logic              rec;
    logic              halt;
    logic              we;

    // Field and immediate extraction.
    assign opc   = instr[6:0];
    assign rd    = instr[11:7];
    assign f3    = alu_func_t'(instr[14:12]);
    assign imm_i = {{20{instr[31]}}, instr[31:20]};
    assign imm_j = {{11{instr[31]}}, instr[31], instr[19:12], instr[20], instr[30:21], 1'b0};
    assign imm_u = {instr[31:12], 12'h000};
    assign pc4   = pc + 32'd4;
    assign halt  = (instr == 32'd0);

    // Operand and alternate-form select; bit 30 means SUB only in the register form.
    assign opb = (opc == OPC_OP) ? rs2_val : imm_i;
    assign alt = (opc == OPC_OP) ? (instr[30] && (f3 == F3_ADD || f3 == F3_SR))
                                 : (instr[30] && f3 == F3_SR);
    assign sh  = opb[4:0];

    // ALU.
    always_comb
    begin
        unique case (f3)
            F3_ADD:  alu_out = alt ? rs1_val - opb : rs1_val + opb;
            F3_SLL:  alu_out = rs1_val << sh;
            F3_SLT:  alu_out = {31'd0, $signed(rs1_val) < $signed(opb)};
            F3_SLTU: alu_out = {31'd0, rs1_val < opb};
            F3_XOR:  alu_out = rs1_val ^ opb;
            F3_SR:   alu_out = alt ? XLEN'($signed(rs1_val) >>> sh) : rs1_val >> sh;
            F3_OR:   alu_out = rs1_val | opb;
            F3_AND:  alu_out = rs1_val & opb;
            default: alu_out = '0;
        endcase
    end

    // Opcode dispatch for result value and next PC.
    always_comb
    begin
        val = '0;
        npc = pc4;
        rec = 1'b1;
        unique case (opc)
            OPC_OP_IMM, OPC_OP: val = alu_out;
            OPC_LUI:            val = imm_u;
            OPC_AUIPC:          val = pc + imm_u;
            OPC_JAL:
            begin
                val = pc4;
                npc = pc + imm_j;
            end
            OPC_JALR:
            begin
                val = pc4;
                npc = (rs1_val + imm_i) & ~32'd1;
            end
            default:            rec = 1'b0;
        endcase
    end

    // The halt word changes nothing and keeps the PC.
    assign we = rec && (rd != REG_ZERO);

    always_comb
    begin
        res.we     = we;
        res.rd     = rd;
        res.val    = we ? val : '0;
        res.npc    = halt ? pc : npc;
        res.rec    = rec;
        res.halted = halt;
    end

endmodule

FILE: rtl/rv32i_alu_jump_execute.sv
// Top level of the RV32I ALU and jump execute block: pipeline control, PC and result register.
//
// Usage:
//   Input channel: one instruction word per beat on instruction_word, qualified by
//   in_valid and held off by in_stall. Output channel: one result beat per instruction
//   (write_enable, dest_reg, write_value, next_pc, recognized, halted), qualified by
//   out_valid and held off by out_stall.
//   An accepted beat is held in the instruction and register file read registers, then in
//   the result register. Throughput is one instruction per cycle while out_stall is low;
//   the first stage reads the two-port register file memory into registers, the second
//   executes and loads the result register while the register file and PC are written.
//   A write by the instruction just ahead is bypassed, so dependent instructions
//   may follow back to back.
//   An all-zero word produces a halted beat and leaves all state alone; later beats
//   execute normally.
//   Reset clears the PC to zero, marks every register as zero and empties both stages.
//   When the receiver stalls, the result register holds; the execute stage holds its
//   instruction, and in_stall rises only when that stage is also full.
module rv32i_alu_jump_execute
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] instruction_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        write_enable,
    output logic [4:0]  dest_reg,
    output logic [31:0] write_value,
    output logic [31:0] next_pc,
    output logic        recognized,
    output logic        halted
);
    import rvaj_pkg::*;

    logic            s1_valid_reg;
    logic            s1_valid_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic [31:0]     instr_reg;
    logic [XLEN-1:0] pc_reg;
    logic [XLEN-1:0] rs1_val;
    logic [XLEN-1:0] rs2_val;
    logic            accept;
    logic            advance;
    exec_result_t    res;
    exec_result_t    res_reg;

    // Handshake: the execute stage moves on when the result register is free or draining.
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pc_reg        <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                pc_reg <= res.npc;
            end
        end
    end

    // Instruction register, loaded alongside the register file read.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            instr_reg <= instruction_word;
        end
    end

    // Register file read on accept, written when an instruction commits.
    rvaj_regfile u_regfile
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept),
        .rs1_addr (instruction_word[19:15]),
        .rs2_addr (instruction_word[24:20]),
        .wr_en    (advance && res.we),
        .wr_addr  (res.rd),
        .wr_data  (res.val),
        .rs1_data (rs1_val),
        .rs2_data (rs2_val)
    );

    // Execute.
    rvaj_exec u_exec
    (
        .instr   (instr_reg),
        .pc      (pc_reg),
        .rs1_val (rs1_val),
        .rs2_val (rs2_val),
        .res     (res)
    );

    // Result register.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign write_enable = res_reg.we;
    assign dest_reg     = res_reg.rd;
    assign write_value  = res_reg.val;
    assign next_pc      = res_reg.npc;
    assign recognized   = res_reg.rec;
    assign halted       = res_reg.halted;

    // An empty execute stage never holds off the sender.
    assert property (@(posedge clk) disable iff (!rst_n) !s1_valid_reg |-> !in_stall)
        else $error("stall with empty execute stage");

    // A halt commit leaves the PC where it was.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.halted |=> pc_reg == $past(pc_reg))
        else $error("halt moved the PC");

    // Only recognized instructions write, and a suppressed write reports zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!res_reg.we || res_reg.rec) && (res_reg.we || res_reg.val == '0))
        else $error("inconsistent write report");

    // The committed PC is the one reported on the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> next_pc == pc_reg)
        else $error("reported next PC differs from PC");

endmodule
